[hdl/blb_pkg.sv]
package blb_pkg;

  // Field widths of the command and result words
  localparam int CMD_W    = 3;
  localparam int LNUM_W   = 4;
  localparam int AMT_W    = 6;
  localparam int DATA_W   = 32;
  localparam int RIDX_W   = 4;
  localparam int STATUS_W = 4;
  localparam int CNT_W    = 5;
  // Wide enough for capacity plus delta against the largest capacity limit
  localparam int SIZE_W   = 10;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_LAST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_VAL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESIZE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LIST     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 4'd2;
  localparam logic [STATUS_W-1:0] ST_EXISTS       = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FULL         = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NO_LIST      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 4'd8;
  localparam logic [STATUS_W-1:0] ST_BAD_NEW_SIZE = 4'd9;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX    = 4'd10;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_READ = 6'b000100,
    S_SRCH = 6'b001000,
    S_SHRD = 6'b010000,
    S_SHWR = 6'b100000
  } state_t;

endpackage

[hdl/bounded_list_bank.sv]
// Bank of NUM_LISTS numbered lists (1-based) of signed 32-bit words, each list
// with its own capacity (up to MAX_CAP) and fill count.
// Command channel: drive cmd, list_number, size_amount, item_value and
// read_index and raise start; the word is taken at a rising edge where start
// is high and busy is low. busy stays high until the result is out.
// Result channel: done is high for exactly one cycle with status, fill_count
// and read_value; the receiver cannot stall it, so it must take it then.
// Create, append, remove last, resize, unknown commands and errors found at the
// check finish from the execute state; read finishes from the read state.
// Remove by value scans the row one word a cycle, then moves each later word
// down with a read and a write on the single-port element store.
// A new command can be taken in the cycle that done is high.
// The element store holds all rows in one single-port memory with registered
// reads; its contents need no clearing. Reset clears the sequencer state, done
// and the per-list capacity, count and created flags, at once.
module bounded_list_bank
  import blb_pkg::*;
#(
  parameter int NUM_LISTS = 10,
  parameter int MAX_CAP   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [LNUM_W-1:0]        list_number,
  input  logic signed [AMT_W-1:0]  size_amount,
  input  logic signed [DATA_W-1:0] item_value,
  input  logic [RIDX_W-1:0]        read_index,
  output logic                     busy,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [CNT_W-1:0]         fill_count,
  output logic signed [DATA_W-1:0] read_value
);

  localparam int DEPTH  = NUM_LISTS * MAX_CAP;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              mem_en, mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  // Command sequencer and list bookkeeping
  blb_ctrl #(
    .NUM_LISTS (NUM_LISTS),
    .MAX_CAP   (MAX_CAP),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .list_number (list_number),
    .size_amount (size_amount),
    .item_value  (item_value),
    .read_index  (read_index),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .fill_count  (fill_count),
    .read_value  (read_value),
    .mem_en      (mem_en),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  // Element rows
  blb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

[hdl/blb_store.sv]
module blb_store
  import blb_pkg::*;
#(
  parameter int DEPTH  = 160,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Single port: write, or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hdl/blb_ctrl.sv]
module blb_ctrl
  import blb_pkg::*;
#(
  parameter int NUM_LISTS = 10,
  parameter int MAX_CAP   = 16,
  parameter int ADDR_W    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [LNUM_W-1:0]          list_number,
  input  logic signed [AMT_W-1:0]    size_amount,
  input  logic signed [DATA_W-1:0]   item_value,
  input  logic [RIDX_W-1:0]          read_index,
  output logic                       busy,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [CNT_W-1:0]           fill_count,
  output logic signed [DATA_W-1:0]   read_value,
  output logic                       mem_en,
  output logic                       mem_we,
  output logic [ADDR_W-1:0]          mem_addr,
  output logic [DATA_W-1:0]          mem_wdata,
  input  logic [DATA_W-1:0]          mem_rdata
);

  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam logic signed [SIZE_W-1:0] MAX_CAP_S = SIZE_W'(MAX_CAP);
  localparam logic [LNUM_W-1:0] NUM_LISTS_L = LNUM_W'(NUM_LISTS);

  state_t state, state_next;

  // Latched command word
  logic [CMD_W-1:0]         cmd_q;
  logic [LIST_W-1:0]        lst;
  logic                     lst_ok;
  logic signed [AMT_W-1:0]  amt;
  logic [DATA_W-1:0]        val;
  logic [RIDX_W-1:0]        ridx;

  // Position inside the addressed row
  logic [CNT_W-1:0] pos, pos_next;

  // Per-list bookkeeping
  logic [CNT_W-1:0] cap_arr [NUM_LISTS];
  logic [CNT_W-1:0] cnt_arr [NUM_LISTS];
  logic             ex_arr  [NUM_LISTS];

  logic [CNT_W-1:0] cur_cap, cur_cnt, cap_new, cnt_new;
  logic             cur_ex, ex_new, meta_we;

  logic                       fin;
  logic [STATUS_W-1:0]        fin_status;
  logic [CNT_W-1:0]           fin_fill;
  logic [DATA_W-1:0]          fin_rval;
  logic [CNT_W-1:0]           mem_pos;

  logic signed [SIZE_W-1:0]   amt_w, ncap, cnt_w, ridx_w;
  logic                       cmd_known;
  logic                       pos1_lt_cnt;

  assign busy     = (state != S_IDLE);
  assign cur_cap  = cap_arr[lst];
  assign cur_cnt  = cnt_arr[lst];
  assign cur_ex   = ex_arr[lst];
  assign amt_w    = SIZE_W'(amt);
  assign ncap     = $signed({{(SIZE_W-CNT_W){1'b0}}, cur_cap}) + amt_w;
  assign cnt_w    = $signed({{(SIZE_W-CNT_W){1'b0}}, cur_cnt});
  assign ridx_w   = $signed({{(SIZE_W-RIDX_W){1'b0}}, ridx});
  assign cmd_known = (cmd_q == CMD_APPEND) || (cmd_q == CMD_REM_LAST) ||
                     (cmd_q == CMD_REM_VAL) || (cmd_q == CMD_RESIZE) ||
                     (cmd_q == CMD_READ);
  assign pos1_lt_cnt = ({1'b0, pos} + (CNT_W+1)'(1)) < {1'b0, cur_cnt};

  // Row base plus position gives the store address
  assign mem_addr = ADDR_W'(lst) * ADDR_W'(MAX_CAP) + ADDR_W'(mem_pos);

  // Sequence one command: check, access the row, finish
  always_comb begin
    state_next = state;
    pos_next   = pos;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_fill   = cur_cnt;
    fin_rval   = '0;
    meta_we    = 1'b0;
    cap_new    = cur_cap;
    cnt_new    = cur_cnt;
    ex_new     = cur_ex;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_pos    = pos;
    mem_wdata  = mem_rdata;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        fin = 1'b1;
        if (!lst_ok) begin
          fin_status = ST_BAD_LIST;
          fin_fill   = '0;
        end else if (cmd_known && !cur_ex) begin
          fin_status = ST_NO_LIST;
        end else begin
          case (cmd_q)
            CMD_CREATE: begin
              if (amt < 1) begin
                fin_status = ST_BAD_SIZE;
              end else if (cur_ex) begin
                fin_status = ST_EXISTS;
              end else if (amt_w > MAX_CAP_S) begin
                fin_status = ST_NO_MEMORY;
              end else begin
                meta_we  = 1'b1;
                ex_new   = 1'b1;
                cap_new  = amt[CNT_W-1:0];
                cnt_new  = '0;
                fin_fill = '0;
              end
            end
            CMD_APPEND: begin
              if (cur_cnt < cur_cap && cnt_w < MAX_CAP_S) begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_pos   = cur_cnt;
                mem_wdata = val;
                meta_we   = 1'b1;
                cnt_new   = cur_cnt + CNT_W'(1);
                fin_fill  = cnt_new;
              end else begin
                fin_status = ST_FULL;
              end
            end
            CMD_REM_LAST: begin
              if (cur_cnt == '0) begin
                fin_status = ST_EMPTY;
              end else begin
                meta_we  = 1'b1;
                cnt_new  = cur_cnt - CNT_W'(1);
                fin_fill = cnt_new;
              end
            end
            CMD_REM_VAL: begin
              if (cur_cnt == '0) begin
                fin_status = ST_EMPTY;
              end else begin
                // start the search at the head of the row
                fin        = 1'b0;
                mem_en     = 1'b1;
                mem_pos    = '0;
                pos_next   = '0;
                state_next = S_SRCH;
              end
            end
            CMD_RESIZE: begin
              if (ncap < 1) begin
                fin_status = ST_BAD_NEW_SIZE;
              end else if (ncap > MAX_CAP_S) begin
                fin_status = ST_NO_MEMORY;
              end else begin
                meta_we = 1'b1;
                cap_new = ncap[CNT_W-1:0];
                if (cnt_w > ncap) begin
                  cnt_new = ncap[CNT_W-1:0];
                end
                fin_fill = cnt_new;
              end
            end
            CMD_READ: begin
              if (ridx_w >= cnt_w || ridx_w >= MAX_CAP_S) begin
                fin_status = ST_BAD_INDEX;
              end else begin
                fin        = 1'b0;
                mem_en     = 1'b1;
                mem_pos    = CNT_W'(ridx);
                state_next = S_READ;
              end
            end
            default: begin
              fin_status = ST_OK;
            end
          endcase
        end
        if (fin) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        fin        = 1'b1;
        fin_rval   = mem_rdata;
        state_next = S_IDLE;
      end
      S_SRCH: begin
        if (mem_rdata == val) begin
          // drop this entry; later entries move down one place
          meta_we = 1'b1;
          cnt_new = cur_cnt - CNT_W'(1);
          if (pos1_lt_cnt) begin
            mem_en     = 1'b1;
            mem_pos    = pos + CNT_W'(1);
            state_next = S_SHWR;
          end else begin
            fin        = 1'b1;
            fin_fill   = cnt_new;
            state_next = S_IDLE;
          end
        end else if (!pos1_lt_cnt) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          mem_en   = 1'b1;
          mem_pos  = pos + CNT_W'(1);
          pos_next = pos + CNT_W'(1);
        end
      end
      S_SHRD: begin
        mem_en     = 1'b1;
        mem_pos    = pos + CNT_W'(1);
        state_next = S_SHWR;
      end
      S_SHWR: begin
        // count already holds the shortened length here
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_pos   = pos;
        mem_wdata = mem_rdata;
        pos_next  = pos + CNT_W'(1);
        if (pos1_lt_cnt) begin
          state_next = S_SHRD;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        cap_arr[i] <= '0;
        cnt_arr[i] <= '0;
        ex_arr[i]  <= 1'b0;
      end
    end else begin
      state <= state_next;
      done  <= fin;
      if (meta_we) begin
        cap_arr[lst] <= cap_new;
        cnt_arr[lst] <= cnt_new;
        ex_arr[lst]  <= ex_new;
      end
    end
  end

  // Capture the command word and the result word
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (start && !busy) begin
      cmd_q  <= cmd;
      lst_ok <= (list_number != '0) && (list_number <= NUM_LISTS_L);
      lst    <= LIST_W'(list_number - LNUM_W'(1));
      amt    <= size_amount;
      val    <= item_value;
      ridx   <= read_index;
    end
    if (fin) begin
      status     <= fin_status;
      fill_count <= fin_fill;
      read_value <= fin_rval;
    end
  end

endmodule
